// ----- rtl/core/lesf_pkg.sv -----
// ----------------------------------------------------------------------------
// Largest empty square finder: shared package
// Field widths, reset values, register indexes and the records that travel
// between the front part, the queue and the back part.
// ----------------------------------------------------------------------------
package lesf_pkg;

	// Widths of the interface fields.
	localparam int CHAR_W    = 8;
	localparam int MAPW_W    = 11;
	localparam int VAL_W     = 11;
	localparam int TOPROW_W  = 12;
	localparam int LEFTCOL_W = 10;

	// Reset values of the configuration registers.
	localparam logic [CHAR_W-1:0] OBSTACLE_RESET  = 8'd111;
	localparam logic [MAPW_W-1:0] MAP_WIDTH_RESET = 11'd1024;

	// Queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_OBSTACLE_CHAR = 1'b0,
		REG_MAP_WIDTH     = 1'b1
	} cfg_reg_t;

	// Classification of one cell, made by the front part.
	typedef struct packed {
		logic active;     // cell takes part in the search
		logic obstacle;   // cell holds the obstacle character
		logic first_line; // first row or first column of the map
		logic last;       // final cell of the map
		logic ovf;        // map has already run past the supported rows
	} cell_flags_t;

	// One result record.
	typedef struct packed {
		logic [VAL_W-1:0]     size;
		logic [TOPROW_W-1:0]  top;
		logic [LEFTCOL_W-1:0] left;
		logic                 ovf;
	} result_t;

endpackage

// ----- rtl/core/lesf_queue.sv -----
// ----------------------------------------------------------------------------
// Largest empty square finder: decoupling queue
// A short first-in first-out store that lets the front and back parts stall
// independently of each other.
// ----------------------------------------------------------------------------
module lesf_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	import lesf_pkg::*;

	logic [WIDTH-1:0]  entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ----- rtl/core/lesf_front.sv -----
// ----------------------------------------------------------------------------
// Largest empty square finder: front part
// Holds the configuration registers, takes in map cells, tracks the row and
// column position and classifies each cell for the back part.
// ----------------------------------------------------------------------------
module lesf_front #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_ROWS  = 4096,
	parameter int COL_W     = 10,
	parameter int ROW_W     = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Cell channel
	input  logic                           cell_valid,
	output logic                           cell_stall,
	input  logic [lesf_pkg::CHAR_W-1:0]    cell_char,
	input  logic                           last_cell,
	// Configuration channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  lesf_pkg::cfg_reg_t             cfg_index,
	input  logic [lesf_pkg::MAPW_W-1:0]    cfg_data,
	// Queue side
	input  logic                           q_full,
	output logic                           push,
	output lesf_pkg::cell_flags_t          flags,
	output logic [COL_W-1:0]               col,
	output logic [ROW_W-1:0]               row
);
	import lesf_pkg::*;

	localparam int CMP_W = ((COL_W > MAPW_W) ? COL_W : MAPW_W) + 1;

	logic [CHAR_W-1:0] obstacle_q;
	logic [MAPW_W-1:0] width_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic              ovf_q;
	logic              cell_fire;
	logic [CMP_W-1:0]  col_next;
	logic              row_end;
	logic              row_at_max;

	assign cfg_ready  = 1'b1;
	assign cell_stall = q_full;
	assign cell_fire  = cell_valid && !cell_stall;

	// A row ends once the next column reaches the width; a width of zero acts
	// as one and a width beyond the row store acts as its depth.
	assign col_next   = CMP_W'(col_q) + CMP_W'(1);
	assign row_end    = (col_next >= CMP_W'(width_q)) || (col_next >= CMP_W'(MAX_WIDTH));
	assign row_at_max = (row_q == ROW_W'(MAX_ROWS - 1));

	// Classification handed to the queue. Cells past the supported rows are
	// dropped here, except the last one, which still has to report.
	assign push             = cell_fire && (!ovf_q || last_cell);
	assign flags.active     = !ovf_q;
	assign flags.obstacle   = (cell_char == obstacle_q);
	assign flags.first_line = (row_q == '0) || (col_q == '0);
	assign flags.last       = last_cell;
	assign flags.ovf        = ovf_q;
	assign col              = col_q;
	assign row              = row_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obstacle_q <= OBSTACLE_RESET;
			width_q    <= MAP_WIDTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_OBSTACLE_CHAR: obstacle_q <= cfg_data[CHAR_W-1:0];
				REG_MAP_WIDTH:     width_q    <= cfg_data;
				default:           ;
			endcase
		end
	end

	// Map position and overflow tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			ovf_q <= 1'b0;
		end else if (cell_fire) begin
			if (last_cell) begin
				col_q <= '0;
				row_q <= '0;
				ovf_q <= 1'b0;
			end else if (!ovf_q) begin
				if (row_end) begin
					col_q <= '0;
					if (row_at_max) begin
						ovf_q <= 1'b1;
					end else begin
						row_q <= row_q + ROW_W'(1);
					end
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

endmodule

// ----- rtl/core/lesf_back.sv -----
// ----------------------------------------------------------------------------
// Largest empty square finder: back part
// Reads the value of the cell above from the row store, works out the square
// side for the cell, keeps the best square and issues the result on the last
// cell of the map.
// ----------------------------------------------------------------------------
module lesf_back #(
	parameter int MAX_WIDTH = 1024,
	parameter int COL_W     = 10,
	parameter int ROW_W     = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Queue side
	input  logic                  q_empty,
	output logic                  pop,
	input  lesf_pkg::cell_flags_t q_flags,
	input  logic [COL_W-1:0]      q_col,
	input  logic [ROW_W-1:0]      q_row,
	// Result channel
	input  logic                  result_stall,
	output logic                  result_valid,
	output lesf_pkg::result_t     result
);
	import lesf_pkg::*;

	// Row store: one square side per column of the row above.
	logic [VAL_W-1:0]     prev_row_mem [MAX_WIDTH];

	logic                 valid_s1;
	cell_flags_t          flags_s1;
	logic [COL_W-1:0]     col_s1;
	logic [ROW_W-1:0]     row_s1;
	logic [VAL_W-1:0]     up_s1;

	logic [VAL_W-1:0]     left_q;
	logic [VAL_W-1:0]     diag_q;
	logic [VAL_W-1:0]     best_size_q;
	logic [TOPROW_W-1:0]  best_top_q;
	logic [LEFTCOL_W-1:0] best_left_q;
	logic                 result_valid_q;
	result_t              result_q;

	logic                 en;
	logic                 fire;
	logic                 wr_en;
	logic [VAL_W-1:0]     min_ul;
	logic [VAL_W-1:0]     min_all;
	logic [VAL_W-1:0]     v;
	logic                 upd;
	logic [TOPROW_W-1:0]  new_top;
	logic [LEFTCOL_W-1:0] new_left;
	result_t              cur;

	// The whole back part advances unless a finished result is held up.
	assign en    = !(result_valid_q && result_stall);
	assign pop   = en && !q_empty;
	assign fire  = en && valid_s1;
	assign wr_en = fire && flags_s1.active;

	// Square side ending at this cell.
	assign min_ul  = (left_q < up_s1) ? left_q : up_s1;
	assign min_all = (diag_q < min_ul) ? diag_q : min_ul;

	always_comb begin
		if (flags_s1.obstacle) begin
			v = '0;
		end else if (flags_s1.first_line) begin
			v = VAL_W'(1);
		end else begin
			v = min_all + VAL_W'(1);
		end
	end

	// Best square so far, kept as its top-left corner.
	assign upd      = flags_s1.active && (v > best_size_q);
	assign new_top  = TOPROW_W'(row_s1) + TOPROW_W'(1) - TOPROW_W'(v);
	assign new_left = LEFTCOL_W'(col_s1) + LEFTCOL_W'(1) - LEFTCOL_W'(v);

	assign cur.size = upd ? v : best_size_q;
	assign cur.top  = upd ? new_top : best_top_q;
	assign cur.left = upd ? new_left : best_left_q;
	assign cur.ovf  = flags_s1.ovf;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Row store write, and read for the next cell with a bypass of the value
	// being written in the same cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			prev_row_mem[col_s1] <= v;
		end
		if (pop) begin
			up_s1 <= (wr_en && (col_s1 == q_col)) ? v : prev_row_mem[q_col];
		end
	end

	// Control: stage valid, best square and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			best_size_q    <= '0;
			best_top_q     <= '0;
			best_left_q    <= '0;
			result_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1       <= !q_empty;
			result_valid_q <= fire && flags_s1.last;
			if (fire) begin
				if (flags_s1.last) begin
					best_size_q <= '0;
					best_top_q  <= '0;
					best_left_q <= '0;
				end else if (upd) begin
					best_size_q <= v;
					best_top_q  <= new_top;
					best_left_q <= new_left;
				end
			end
		end
	end

	// Payload: stage contents, neighbour values and the result record.
	always_ff @(posedge clk) begin
		if (pop) begin
			flags_s1 <= q_flags;
			col_s1   <= q_col;
			row_s1   <= q_row;
		end
		if (wr_en) begin
			left_q <= v;
			diag_q <= up_s1;
		end
		if (fire && flags_s1.last) begin
			result_q <= cur;
		end
	end

endmodule

// ----- rtl/core/largest_empty_square_finder_unit.sv -----
// ----------------------------------------------------------------------------
// Largest empty square finder
// Scans a character map in row-major order and reports the largest square
// free of obstacle characters when the last cell of the map arrives.
//
//   Channel   Handshake              Payload
//   cell      cell_valid/cell_stall  cell_char, last_cell
//   result    result_valid/stall     square_size, top_row, left_col, overflow
//   config    cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One cell is taken every cycle while cell_stall is low; the last cell passes
// through the queue, the stage register and the result register.
// The row store has one read and one write port; each cell reads it once and writes it at most once.
// Reset clears all control state at once; the row store needs no clearing pass.
// A stalled result holds the back part; the four-entry queue then fills and
// cell_stall rises.
// ----------------------------------------------------------------------------
module largest_empty_square_finder_unit #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_ROWS  = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Cell channel
	input  logic                            cell_valid,
	output logic                            cell_stall,
	input  logic [lesf_pkg::CHAR_W-1:0]     cell_char,
	input  logic                            last_cell,
	// Result channel
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [lesf_pkg::VAL_W-1:0]      square_size,
	output logic [lesf_pkg::TOPROW_W-1:0]   top_row,
	output logic [lesf_pkg::LEFTCOL_W-1:0]  left_col,
	output logic                            overflow,
	// Configuration channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  lesf_pkg::cfg_reg_t              cfg_index,
	input  logic [lesf_pkg::MAPW_W-1:0]     cfg_data
);
	import lesf_pkg::*;

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int Q_W   = $bits(cell_flags_t) + COL_W + ROW_W;

	logic              q_full;
	logic              q_empty;
	logic              push;
	logic              pop;
	cell_flags_t       f_flags;
	logic [COL_W-1:0]  f_col;
	logic [ROW_W-1:0]  f_row;
	logic [Q_W-1:0]    q_din;
	logic [Q_W-1:0]    q_dout;
	cell_flags_t       b_flags;
	logic [COL_W-1:0]  b_col;
	logic [ROW_W-1:0]  b_row;
	result_t           result;

	// Front part: configuration, position tracking and classification.
	lesf_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_ROWS  (MAX_ROWS),
		.COL_W     (COL_W),
		.ROW_W     (ROW_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (cell_valid),
		.cell_stall (cell_stall),
		.cell_char  (cell_char),
		.last_cell  (last_cell),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.push       (push),
		.flags      (f_flags),
		.col        (f_col),
		.row        (f_row)
	);

	// Queue between the two parts.
	assign q_din = {f_flags, f_col, f_row};

	lesf_queue #(
		.WIDTH (Q_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (q_din),
		.full   (q_full),
		.pop    (pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	assign {b_flags, b_col, b_row} = q_dout;

	// Back part: square computation, best tracking and result register.
	lesf_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.COL_W     (COL_W),
		.ROW_W     (ROW_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.pop          (pop),
		.q_flags      (b_flags),
		.q_col        (b_col),
		.q_row        (b_row),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result)
	);

	assign square_size = result.size;
	assign top_row     = result.top;
	assign left_col    = result.left;
	assign overflow    = result.ovf;

endmodule

// ----- rtl/core/lesf_chk.sv -----
// ----------------------------------------------------------------------------
// Largest empty square finder: port checker
// Watches the top-level ports and flags results that cannot be right.
// ----------------------------------------------------------------------------
module lesf_chk #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_ROWS  = 4096
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            result_valid,
	input logic                            result_stall,
	input logic [lesf_pkg::VAL_W-1:0]      square_size,
	input logic [lesf_pkg::TOPROW_W-1:0]   top_row,
	input logic [lesf_pkg::LEFTCOL_W-1:0]  left_col,
	input logic                            overflow
);
	import lesf_pkg::*;

	// A held-up result stays on the port unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(square_size)
			&& $stable(top_row) && $stable(left_col) && $stable(overflow))
		else $error("result changed while stalled");

	// With no free cell the corner must read as zero.
	a_empty_corner: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (square_size == '0) |-> (top_row == '0) && (left_col == '0))
		else $error("corner set for an empty result");

	// The square must lie within the supported rows.
	a_rows_fit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (square_size != '0) |->
			(MAX_ROWS > 4096) || (int'(top_row) + int'(square_size) <= MAX_ROWS))
		else $error("square runs past the supported rows");

	// The square must lie within the row store.
	a_cols_fit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (square_size != '0) |->
			(MAX_WIDTH > 1024) || (int'(left_col) + int'(square_size) <= MAX_WIDTH))
		else $error("square runs past the row width");

endmodule

bind largest_empty_square_finder_unit lesf_chk #(
	.MAX_WIDTH (MAX_WIDTH),
	.MAX_ROWS  (MAX_ROWS)
) u_lesf_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.square_size  (square_size),
	.top_row      (top_row),
	.left_col     (left_col),
	.overflow     (overflow)
);
